@@ hw/rtl/rthsv_pkg.sv @@
`default_nettype none

package rthsv_pkg;

  // channel width
  localparam int unsigned CH_W    = 8;
  // quotient width of both dividers (hue and saturation)
  localparam int unsigned Q_W     = 8;
  // hue numerator N < 6*d <= 1530
  localparam int unsigned H_NUM_W = 11;
  // hue divisor 6*d
  localparam int unsigned H_DIV_W = 11;
  // hue dividend 255*N < 2^19
  localparam int unsigned H_REM_W = 19;
  // saturation dividend 255*d < 2^16
  localparam int unsigned S_REM_W = 16;
  // saturation divisor mx
  localparam int unsigned S_DIV_W = CH_W;

  // front (2) + one divider step per quotient bit + output register
  localparam int unsigned PIPE_DEPTH = 2 + Q_W + 1;

  // after max/min and sector selection
  typedef struct packed {
    logic [CH_W-1:0]    mx;
    logic [CH_W-1:0]    d;
    logic [H_NUM_W-1:0] num;
    logic               grey;
  } sect_t;

  // payload carried through the divider steps
  typedef struct packed {
    logic [H_REM_W-1:0] h_rem;
    logic [H_DIV_W-1:0] h_div;
    logic [Q_W-1:0]     h_q;
    logic [S_REM_W-1:0] s_rem;
    logic [S_DIV_W-1:0] s_div;
    logic [Q_W-1:0]     s_q;
    logic [CH_W-1:0]    mx;
    logic               grey;
  } div_t;

endpackage

`default_nettype wire

@@ hw/rtl/rthsv_rgb_if.sv @@
`default_nettype none

interface rthsv_rgb_if;
  import rthsv_pkg::*;

  logic            valid;
  logic            ready;
  logic [CH_W-1:0] red_in;
  logic [CH_W-1:0] green_in;
  logic [CH_W-1:0] blue_in;

  modport source (output valid, output red_in, output green_in, output blue_in,
                  input ready);
  modport sink   (input valid, input red_in, input green_in, input blue_in,
                  output ready);
endinterface

`default_nettype wire

@@ hw/rtl/rthsv_hsv_if.sv @@
`default_nettype none

interface rthsv_hsv_if;
  import rthsv_pkg::*;

  logic            valid;
  logic            ready;
  logic [CH_W-1:0] hue_out;
  logic [CH_W-1:0] sat_out;
  logic [CH_W-1:0] val_out;

  modport source (output valid, output hue_out, output sat_out, output val_out,
                  input ready);
  modport sink   (input valid, input hue_out, input sat_out, input val_out,
                  output ready);
endinterface

`default_nettype wire

@@ hw/rtl/rthsv_front.sv @@
`default_nettype none

// Two front stages: sector/numerator selection, then scaling by 255 and 6.
module rthsv_front
  import rthsv_pkg::*;
(
  input  logic            clk,
  input  logic            en_sect,
  input  logic            en_scale,
  input  logic [CH_W-1:0] red,
  input  logic [CH_W-1:0] green,
  input  logic [CH_W-1:0] blue,
  output div_t            scaled
);

  logic [CH_W-1:0]    mx_rg;
  logic [CH_W-1:0]    mn_rg;
  logic [CH_W-1:0]    mx;
  logic [CH_W-1:0]    mn;
  logic [CH_W-1:0]    d;
  logic [H_NUM_W-1:0] d_ext;
  logic [H_NUM_W-1:0] d6;
  logic [H_NUM_W-1:0] num;
  sect_t              sect_next;
  sect_t              sect;
  div_t               scaled_next;

  // max, min and spread
  always_comb begin
    mx_rg = (red > green) ? red : green;
    mn_rg = (red < green) ? red : green;
    mx    = (mx_rg > blue) ? mx_rg : blue;
    mn    = (mn_rg < blue) ? mn_rg : blue;
    d     = mx - mn;
    d_ext = H_NUM_W'(d);
    d6    = (d_ext << 2) + (d_ext << 1);
  end

  // hue numerator, first maximum in red, green, blue order wins
  always_comb begin
    priority if (red == mx) begin
      if (green >= blue) begin
        num = H_NUM_W'(green - blue);
      end else begin
        num = d6 - H_NUM_W'(blue - green);
      end
    end else if (green == mx) begin
      num = (d_ext << 1) + H_NUM_W'(blue) - H_NUM_W'(red);
    end else begin
      num = (d_ext << 2) + H_NUM_W'(red) - H_NUM_W'(green);
    end
  end

  always_comb begin
    sect_next.mx   = mx;
    sect_next.d    = d;
    sect_next.num  = num;
    sect_next.grey = (d == '0);
  end

  always_ff @(posedge clk) begin
    if (en_sect) begin
      sect <= sect_next;
    end
  end

  // 255*x as (x<<8)-x, divisor 6*d as (d<<2)+(d<<1)
  always_comb begin
    scaled_next.h_rem = (H_REM_W'(sect.num) << 8) - H_REM_W'(sect.num);
    scaled_next.h_div = (H_DIV_W'(sect.d) << 2) + (H_DIV_W'(sect.d) << 1);
    scaled_next.h_q   = '0;
    scaled_next.s_rem = (S_REM_W'(sect.d) << 8) - S_REM_W'(sect.d);
    scaled_next.s_div = sect.mx;
    scaled_next.s_q   = '0;
    scaled_next.mx    = sect.mx;
    scaled_next.grey  = sect.grey;
  end

  always_ff @(posedge clk) begin
    if (en_scale) begin
      scaled <= scaled_next;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/rthsv_div_stage.sv @@
`default_nettype none

// One restoring-division step for hue and saturation: resolves quotient bit SHIFT.
module rthsv_div_stage
  import rthsv_pkg::*;
#(
  parameter int unsigned SHIFT = 0
) (
  input  logic clk,
  input  logic en,
  input  div_t din,
  output div_t dout
);

  logic [H_REM_W-1:0] h_trial;
  logic [S_REM_W-1:0] s_trial;
  logic               h_take;
  logic               s_take;
  div_t               dout_next;

  always_comb begin
    h_trial   = H_REM_W'(din.h_div) << SHIFT;
    s_trial   = S_REM_W'(din.s_div) << SHIFT;
    h_take    = (din.h_rem >= h_trial);
    s_take    = (din.s_rem >= s_trial);
    dout_next = din;
    if (h_take) begin
      dout_next.h_rem = din.h_rem - h_trial;
    end
    if (s_take) begin
      dout_next.s_rem = din.s_rem - s_trial;
    end
    dout_next.h_q[SHIFT] = h_take;
    dout_next.s_q[SHIFT] = s_take;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dout <= dout_next;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/rgb_to_hsv_pixel.sv @@
`default_nettype none

// RGB to HSV converter, 8 bits per channel.
// rgb (sink): one pixel per item, red_in/green_in/blue_in.
// hsv (source): one result item per pixel, hue_out/sat_out/val_out, in order.
// hue spans 0..254 around the circle; for a grey pixel hue = val = red and
// sat = 0. sat = floor(255*d/max), val = max channel.
// Stages: two front stages, eight divider steps of one quotient bit each
// and one output register; the eight divider steps set the depth.
// Throughput: one item per cycle unless hsv stalls with every stage full.
// Each stage holds its own valid bit and moves forward whenever the next
// stage is empty or moving, so bubbles are squeezed out while hsv stalls and
// rgb.ready stays high until all 11 stages hold items.
// A stalled result holds steady until taken; nothing is lost or repeated.
// Reset (rst, synchronous) empties the pipeline; no items are in flight after.
module rgb_to_hsv_pixel
  import rthsv_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  rthsv_rgb_if.sink   rgb,
  rthsv_hsv_if.source hsv
);

  localparam int unsigned DIV_FIRST = 2;
  localparam int unsigned OUT_STG   = PIPE_DEPTH - 1;

  logic [PIPE_DEPTH-1:0] vld;
  logic [PIPE_DEPTH-1:0] en;
  logic [PIPE_DEPTH-1:0] vld_prev;
  div_t                  div_pipe [Q_W+1];
  logic [CH_W-1:0]       hue;
  logic [CH_W-1:0]       sat;
  logic [CH_W-1:0]       val;

  // stage advance: load when empty or when the downstream stage moves on
  genvar k;
  generate
    for (k = 0; k < PIPE_DEPTH - 1; k++) begin : g_en
      assign en[k] = !vld[k] || en[k+1];
    end
  endgenerate
  assign en[OUT_STG] = !vld[OUT_STG] || hsv.ready;

  assign vld_prev = {vld[PIPE_DEPTH-2:0], rgb.valid};
  assign rgb.ready = en[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int i = 0; i < PIPE_DEPTH; i++) begin
        if (en[i]) begin
          vld[i] <= vld_prev[i];
        end
      end
    end
  end

  rthsv_front u_front (
    .clk      (clk),
    .en_sect  (en[0]),
    .en_scale (en[1]),
    .red      (rgb.red_in),
    .green    (rgb.green_in),
    .blue     (rgb.blue_in),
    .scaled   (div_pipe[0])
  );

  // divider steps, most significant quotient bit first
  generate
    for (k = 0; k < Q_W; k++) begin : g_div
      rthsv_div_stage #(
        .SHIFT (Q_W - 1 - k)
      ) u_div (
        .clk  (clk),
        .en   (en[DIV_FIRST + k]),
        .din  (div_pipe[k]),
        .dout (div_pipe[k+1])
      );
    end
  endgenerate

  // grey pixels bypass both quotients
  always_comb begin
    hue = div_pipe[Q_W].grey ? div_pipe[Q_W].mx : div_pipe[Q_W].h_q;
    sat = div_pipe[Q_W].grey ? '0 : div_pipe[Q_W].s_q;
    val = div_pipe[Q_W].mx;
  end

  always_ff @(posedge clk) begin
    if (en[OUT_STG]) begin
      hsv.hue_out <= hue;
      hsv.sat_out <= sat;
      hsv.val_out <= val;
    end
  end

  assign hsv.valid = vld[OUT_STG];

endmodule

`default_nettype wire

@@ hw/rtl/rthsv_checker.sv @@
`default_nettype none

module rthsv_checker
  import rthsv_pkg::*;
(
  input logic            clk,
  input logic            rst,
  input logic            in_valid,
  input logic            in_ready,
  input logic            out_valid,
  input logic            out_ready,
  input logic [CH_W-1:0] hue_out,
  input logic [CH_W-1:0] sat_out,
  input logic [CH_W-1:0] val_out
);

  localparam int unsigned CNT_W = $clog2(PIPE_DEPTH + 1);

  logic             in_fire;
  logic             out_fire;
  logic [CNT_W-1:0] occ;

  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid && out_ready;

  // items in flight
  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= '0;
    end else if (in_fire && !out_fire) begin
      occ <= occ + 1'b1;
    end else if (out_fire && !in_fire) begin
      occ <= occ - 1'b1;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(hue_out) && $stable(sat_out)
      && $stable(val_out))
    else $error("result changed while stalled");

  a_no_invent: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> occ != '0)
    else $error("result without a pending item");

  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    occ <= CNT_W'(PIPE_DEPTH))
    else $error("more items in flight than pipeline stages");

  a_grey: assert property (@(posedge clk) disable iff (rst)
    out_valid && sat_out == '0 |-> hue_out == val_out)
    else $error("grey result with hue different from value");

  a_hue_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && sat_out != '0 |-> hue_out != '1 && val_out != '0)
    else $error("colored result out of range");

endmodule

bind rgb_to_hsv_pixel rthsv_checker u_rthsv_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (rgb.valid),
  .in_ready  (rgb.ready),
  .out_valid (hsv.valid),
  .out_ready (hsv.ready),
  .hue_out   (hsv.hue_out),
  .sat_out   (hsv.sat_out),
  .val_out   (hsv.val_out)
);

`default_nettype wire

@@ tb/rgb_to_hsv_pixel_tb.sv @@
`default_nettype none

module rgb_to_hsv_pixel_tb
  import rthsv_pkg::*;
;

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } pixel_t;

  typedef struct packed {
    logic [CH_W-1:0] hue;
    logic [CH_W-1:0] sat;
    logic [CH_W-1:0] val;
  } hsv_t;

  // one row of the directed table; known = expected result typed in below
  typedef struct packed {
    pixel_t px;
    logic   known;
    hsv_t   want;
  } pixel_row_t;

  localparam int unsigned NUM_ROWS     = 22;
  localparam int unsigned RANDOM_ITEMS = 930;
  localparam int unsigned MAX_REPORTS  = 10;

  logic clk;
  logic rst;

  rthsv_rgb_if rgb_bus ();
  rthsv_hsv_if hsv_bus ();

  rgb_to_hsv_pixel u_top (
    .clk (clk),
    .rst (rst),
    .rgb (rgb_bus),
    .hsv (hsv_bus)
  );

  hsv_t        pending_hsv [$];
  int unsigned pixels_taken;
  int unsigned fail_count;
  bit          sink_holding;

  // directed pixels: grey levels, primaries, ties, smallest spreads, bit patterns
  pixel_row_t pixel_rows [0:NUM_ROWS-1] = '{
    '{'{8'd0,   8'd0,   8'd0},   1'b1, '{8'd0,   8'd0,   8'd0}},
    '{'{8'd255, 8'd255, 8'd255}, 1'b1, '{8'd255, 8'd0,   8'd255}},
    '{'{8'd128, 8'd128, 8'd128}, 1'b1, '{8'd128, 8'd0,   8'd128}},
    '{'{8'd1,   8'd1,   8'd1},   1'b1, '{8'd1,   8'd0,   8'd1}},
    '{'{8'd255, 8'd0,   8'd0},   1'b1, '{8'd0,   8'd255, 8'd255}},
    '{'{8'd0,   8'd255, 8'd0},   1'b1, '{8'd85,  8'd255, 8'd255}},
    '{'{8'd0,   8'd0,   8'd255}, 1'b1, '{8'd170, 8'd255, 8'd255}},
    '{'{8'd1,   8'd0,   8'd0},   1'b1, '{8'd0,   8'd255, 8'd1}},
    '{'{8'd255, 8'd255, 8'd0},   1'b0, '0},
    '{'{8'd255, 8'd0,   8'd255}, 1'b0, '0},
    '{'{8'd0,   8'd255, 8'd255}, 1'b0, '0},
    '{'{8'd255, 8'd0,   8'd1},   1'b0, '0},
    '{'{8'd254, 8'd255, 8'd255}, 1'b0, '0},
    '{'{8'd255, 8'd254, 8'd254}, 1'b0, '0},
    '{'{8'd0,   8'd1,   8'd1},   1'b0, '0},
    '{'{8'd128, 8'd64,  8'd200}, 1'b0, '0},
    '{'{8'd10,  8'd200, 8'd30},  1'b0, '0},
    '{'{8'd170, 8'd85,  8'd170}, 1'b0, '0},
    '{'{8'd85,  8'd170, 8'd85},  1'b0, '0},
    '{'{8'd200, 8'd100, 8'd99},  1'b0, '0},
    '{'{8'd1,   8'd2,   8'd3},   1'b0, '0},
    '{'{8'd255, 8'd128, 8'd0},   1'b0, '0}
  };

  // exact integer HSV of one pixel
  function automatic hsv_t hsv_of_pixel(pixel_t px);
    logic [CH_W-1:0]    peak;
    logic [CH_W-1:0]    low_ch;
    logic [CH_W-1:0]    spread;
    logic [H_NUM_W-1:0] hue_num;
    logic [H_REM_W-1:0] hue_prod;
    logic [H_DIV_W-1:0] hue_div;
    logic [S_REM_W-1:0] sat_prod;
    hsv_t               res;
    peak   = (px.red > px.green) ? px.red : px.green;
    peak   = (peak > px.blue) ? peak : px.blue;
    low_ch = (px.red < px.green) ? px.red : px.green;
    low_ch = (low_ch < px.blue) ? low_ch : px.blue;
    spread = peak - low_ch;
    // grey: hue and value both carry red
    if (spread == '0) begin
      res.hue = px.red;
      res.sat = '0;
      res.val = px.red;
      return res;
    end
    sat_prod = S_REM_W'(spread) * S_REM_W'(255);
    res.sat  = CH_W'(sat_prod / S_REM_W'(peak));
    // first maximum in red, green, blue order picks the sector
    if (px.red == peak) begin
      if (px.green >= px.blue)
        hue_num = H_NUM_W'(px.green - px.blue);
      else
        hue_num = H_NUM_W'(6 * spread) - H_NUM_W'(px.blue - px.green);
    end else if (px.green == peak) begin
      hue_num = H_NUM_W'(2 * spread) + H_NUM_W'(px.blue) - H_NUM_W'(px.red);
    end else begin
      hue_num = H_NUM_W'(4 * spread) + H_NUM_W'(px.red) - H_NUM_W'(px.green);
    end
    hue_prod = H_REM_W'(hue_num) * H_REM_W'(255);
    hue_div  = H_DIV_W'(6 * spread);
    res.hue  = CH_W'(hue_prod / H_REM_W'(hue_div));
    res.val  = peak;
    return res;
  endfunction

  // random pixel, weighted toward greys, ties, small spreads and extremes
  function automatic pixel_t random_pixel();
    pixel_t      px;
    logic [7:0]  base;
    int unsigned pick;
    int unsigned lo;
    int unsigned hi;
    px   = pixel_t'({$urandom(), $urandom()});
    base = 8'($urandom());
    pick = $urandom_range(0, 9);
    case (pick)
      0: begin
        px = '{base, base, base};
      end
      1: begin
        // two channels share the maximum
        px = '{base, base, 8'($urandom_range(0, base))};
        case ($urandom_range(0, 2))
          0: px = '{px.red, px.blue, px.green};
          1: px = '{px.blue, px.red, px.green};
          default: ;
        endcase
      end
      2: begin
        lo = (base < 2) ? 0 : base - 2;
        hi = (base > 253) ? 255 : base + 2;
        px = '{base, 8'($urandom_range(lo, hi)), 8'($urandom_range(lo, hi))};
      end
      3: begin
        px.red   = $urandom_range(0, 1) ? 8'hff : 8'h00;
        px.green = $urandom_range(0, 1) ? 8'hff : base;
        px.blue  = $urandom_range(0, 1) ? 8'h00 : 8'($urandom());
      end
      default: ;
    endcase
    return px;
  endfunction

  // offer one item and hold it until taken; queue its expected result
  task automatic send_pixel(pixel_t px, hsv_t want);
    rgb_bus.valid    <= 1'b1;
    rgb_bus.red_in   <= px.red;
    rgb_bus.green_in <= px.green;
    rgb_bus.blue_in  <= px.blue;
    do @(posedge clk); while (!rgb_bus.ready);
    pending_hsv.push_back(want);
    pixels_taken++;
  endtask

  task automatic note_mismatch(string what, hsv_t want, hsv_t seen);
    fail_count++;
    if (fail_count <= MAX_REPORTS)
      $display("%0t: %s exp h=%0d s=%0d v=%0d got h=%0d s=%0d v=%0d", $realtime, what,
               want.hue, want.sat, want.val, seen.hue, seen.sat, seen.val);
  endtask

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // result checker
  always @(posedge clk) begin : hsv_check
    hsv_t seen;
    hsv_t want;
    if (!rst && hsv_bus.valid && hsv_bus.ready) begin
      seen = '{hsv_bus.hue_out, hsv_bus.sat_out, hsv_bus.val_out};
      if (pending_hsv.size() == 0) begin
        note_mismatch("unexpected item", '0, seen);
      end else begin
        want = pending_hsv.pop_front();
        if (seen.hue !== want.hue || seen.sat !== want.sat || seen.val !== want.val)
          note_mismatch("mismatch", want, seen);
      end
    end
  end

  // receiver: rotating stall patterns plus one long hold-off
  initial begin : hsv_sink
    int unsigned cyc;
    int unsigned hold_left;
    bit          hold_done;
    logic        take;
    cyc          = 0;
    hold_left    = 0;
    hold_done    = 1'b0;
    sink_holding = 1'b0;
    hsv_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      cyc++;
      if (!hold_done && pixels_taken >= 300) begin
        hold_left = 64;
        hold_done = 1'b1;
      end
      if (hold_left != 0) begin
        hold_left--;
        sink_holding = (hold_left != 0);
        take = 1'b0;
      end else begin
        case ((cyc / 150) % 4)
          0: take = 1'b1;
          1: take = ($urandom_range(0, 9) < 7);
          2: take = ((cyc % 5) < 3);
          default: take = ($urandom_range(0, 9) < 3);
        endcase
      end
      hsv_bus.ready <= take;
    end
  end

  // run limit
  initial begin
    #2_000_000;
    $display("FAIL");
    $finish;
  end

  // stimulus
  initial begin : pixel_source
    pixel_t      px;
    hsv_t        want;
    int unsigned burst_left;
    int unsigned gap;
    int unsigned drain;
    pixels_taken = 0;
    fail_count   = 0;
    rst              <= 1'b1;
    rgb_bus.valid    <= 1'b0;
    rgb_bus.red_in   <= '0;
    rgb_bus.green_in <= '0;
    rgb_bus.blue_in  <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table
    for (int i = 0; i < NUM_ROWS; i++) begin
      want = pixel_rows[i].known ? pixel_rows[i].want : hsv_of_pixel(pixel_rows[i].px);
      send_pixel(pixel_rows[i].px, want);
    end

    // random bursts with random gaps; no gaps while the receiver holds off
    burst_left = $urandom_range(1, 24);
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        gap        = sink_holding ? 0 : $urandom_range(1, 6);
        if (gap != 0) begin
          rgb_bus.valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      burst_left--;
      px = random_pixel();
      send_pixel(px, hsv_of_pixel(px));
    end
    rgb_bus.valid <= 1'b0;

    // drain, then watch for stray items
    drain = 0;
    while (pending_hsv.size() != 0 && drain < 20000) begin
      @(posedge clk);
      drain++;
    end
    repeat (PIPE_DEPTH + 8) @(posedge clk);
    if (fail_count == 0 && pending_hsv.size() == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule

`default_nettype wire

@@ filelist.f @@
hw/rtl/rthsv_pkg.sv
hw/rtl/rthsv_rgb_if.sv
hw/rtl/rthsv_hsv_if.sv
hw/rtl/rthsv_front.sv
hw/rtl/rthsv_div_stage.sv
hw/rtl/rgb_to_hsv_pixel.sv
hw/rtl/rthsv_checker.sv
tb/rgb_to_hsv_pixel_tb.sv
